// ===== sv/lst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, character codes, token kinds and helper functions for the
// Lisp source tokenizer. No dependencies.
package lst_pkg;

    localparam int LINE_BITS = 16;
    localparam int CMP_W     = (LINE_BITS > 16) ? LINE_BITS : 16;

    typedef logic [LINE_BITS-1:0] line_t;

    localparam line_t LINE_TOP = '1;

    // Token kinds.
    localparam logic [3:0] KIND_LPAREN   = 4'd0;
    localparam logic [3:0] KIND_RPAREN   = 4'd1;
    localparam logic [3:0] KIND_LBRACKET = 4'd2;
    localparam logic [3:0] KIND_RBRACKET = 4'd3;
    localparam logic [3:0] KIND_NUMBER   = 4'd4;
    localparam logic [3:0] KIND_INTEGER  = 4'd5;
    localparam logic [3:0] KIND_CHAR     = 4'd6;
    localparam logic [3:0] KIND_STRING   = 4'd7;
    localparam logic [3:0] KIND_IDENT    = 4'd8;
    localparam logic [3:0] KIND_EOF      = 4'd9;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_UNTERM   = 3'd1;
    localparam logic [2:0] ERR_ESCAPE   = 3'd2;
    localparam logic [2:0] ERR_DOUBLE   = 3'd3;
    localparam logic [2:0] ERR_TRAILING = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_NL         = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LBRACKET   = 8'h5B;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic [7:0]  text;
        logic        text_valid;
        logic [3:0]  kind;
        logic [15:0] line;
        logic        last;
        logic [2:0]  err;
    } tok_t;

    // Up to three result items produced by one accepted source byte.
    typedef struct packed {
        logic [1:0]      count;
        tok_t [2:0]      items;
    } burst_t;

    function automatic logic [15:0] out_line(line_t l);
        logic [CMP_W-1:0] w;
        w = CMP_W'(l);
        return (w > CMP_W'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic line_t load_line(logic [15:0] f);
        logic [CMP_W-1:0] w;
        w = CMP_W'(f);
        return (w > CMP_W'(LINE_TOP)) ? LINE_TOP : w[LINE_BITS-1:0];
    endfunction

    function automatic line_t bump_line(line_t l);
        return (l == LINE_TOP) ? l : l + line_t'(1);
    endfunction

    function automatic tok_t make_tok(logic [7:0] text, logic text_valid, logic [3:0] kind,
                                      line_t line, logic last, logic [2:0] err);
        tok_t t;
        t.text       = text;
        t.text_valid = text_valid;
        t.kind       = kind;
        t.line       = out_line(line);
        t.last       = last;
        t.err        = err;
        return t;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    // Bit 8 set when the escape is known; bits 7:0 hold the mapped byte.
    function automatic logic [8:0] map_escape(logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            8'h61:     r = {1'b1, 8'd7};
            8'h62:     r = {1'b1, 8'd8};
            8'h74:     r = {1'b1, 8'd9};
            8'h6E:     r = {1'b1, 8'd10};
            8'h76:     r = {1'b1, 8'd11};
            8'h66:     r = {1'b1, 8'd12};
            8'h72:     r = {1'b1, 8'd13};
            8'h65:     r = {1'b1, 8'd27};
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_QUOTE:  r = {1'b1, CH_QUOTE};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/lst_scan.sv =====
`timescale 1ns / 1ps
// Scanner state and per-byte token logic of the Lisp source tokenizer.
// Depends on lst_pkg; produces a burst of up to three result items per byte.
module lst_scan (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      source_byte,
    input  logic            end_of_input,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_first_line,
    input  logic [15:0]     first_line,
    output lst_pkg::burst_t burst
);
    import lst_pkg::*;

    typedef enum logic [3:0] {
        MODE_IDLE       = 4'd0,
        MODE_COMMENT    = 4'd1,
        MODE_CHAR       = 4'd2,
        MODE_CHAR_ESC   = 4'd3,
        MODE_STRING     = 4'd4,
        MODE_STRING_ESC = 4'd5,
        MODE_MINUS      = 4'd6,
        MODE_NUMBER     = 4'd7,
        MODE_IDENT      = 4'd8,
        MODE_ERROR      = 4'd9
    } mode_t;

    mode_t      mode_reg, mode_next;
    line_t      line_reg, line_next;
    line_t      start_reg, start_next;
    logic       dot_reg, dot_next;
    logic       sep_reg, sep_next;
    logic [2:0] errc_reg, errc_next;
    line_t      errl_reg, errl_next;
    logic       at_start_reg, at_start_next;

    logic [1:0] n;
    logic       do_idle;
    logic       failed;
    logic [2:0] fail_code;
    line_t      fail_line;
    logic [8:0] esc;
    logic       ident_end;
    logic [3:0] num_kind;

    assign esc       = map_escape(source_byte);
    assign num_kind  = dot_reg ? KIND_NUMBER : KIND_INTEGER;
    assign ident_end = (source_byte == CH_DQUOTE) || (source_byte == CH_QUOTE) ||
                       (source_byte == CH_SEMI) || (source_byte == CH_LPAREN) ||
                       (source_byte == CH_RPAREN) || is_space(source_byte);

    always_comb
    begin
        mode_next     = mode_reg;
        line_next     = line_reg;
        start_next    = start_reg;
        dot_next      = dot_reg;
        sep_next      = sep_reg;
        errc_next     = errc_reg;
        errl_next     = errl_reg;
        at_start_next = at_start_reg;
        burst         = '0;
        n             = 2'd0;
        do_idle       = 1'b0;
        failed        = 1'b0;
        fail_code     = ERR_NONE;
        fail_line     = line_reg;

        // A new first line takes effect at once while no text has started.
        if (cfg_we && at_start_reg && mode_reg == MODE_IDLE)
        begin
            line_next = load_line(cfg_first_line);
        end

        if (accept)
        begin
            if (mode_reg == MODE_ERROR)
            begin
                burst.items[0] = make_tok(8'd0, 1'b0, KIND_EOF, errl_reg, 1'b1, errc_reg);
                n = 2'd1;
            end
            else if (end_of_input)
            begin
                unique case (mode_reg)
                    MODE_COMMENT: line_next = bump_line(line_reg);
                    MODE_CHAR:
                    begin
                        burst.items[0] = make_tok(8'd0, 1'b1, KIND_CHAR, line_reg, 1'b1,
                                                  ERR_NONE);
                        n = 2'd1;
                    end
                    MODE_CHAR_ESC, MODE_STRING_ESC:
                    begin
                        failed    = 1'b1;
                        fail_code = ERR_ESCAPE;
                    end
                    MODE_STRING:
                    begin
                        failed    = 1'b1;
                        fail_code = ERR_UNTERM;
                        fail_line = start_reg;
                    end
                    MODE_MINUS:
                    begin
                        burst.items[0] = make_tok(CH_MINUS, 1'b1, KIND_IDENT, line_reg, 1'b0,
                                                  ERR_NONE);
                        burst.items[1] = make_tok(8'd0, 1'b0, KIND_IDENT, line_reg, 1'b1,
                                                  ERR_NONE);
                        n = 2'd2;
                    end
                    MODE_NUMBER:
                    begin
                        if (sep_reg)
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_TRAILING;
                        end
                        else
                        begin
                            burst.items[0] = make_tok(8'd0, 1'b0, num_kind, line_reg, 1'b1,
                                                      ERR_NONE);
                            n = 2'd1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        burst.items[0] = make_tok(8'd0, 1'b0, KIND_IDENT, line_reg, 1'b1,
                                                  ERR_NONE);
                        n = 2'd1;
                    end
                    default: ;
                endcase
                if (!failed)
                begin
                    burst.items[n] = make_tok(8'd0, 1'b0, KIND_EOF, line_next, 1'b1, ERR_NONE);
                    n             = n + 2'd1;
                    mode_next     = MODE_IDLE;
                    line_next     = load_line(first_line);
                    dot_next      = 1'b0;
                    sep_next      = 1'b0;
                    at_start_next = 1'b1;
                end
            end
            else
            begin
                at_start_next = 1'b0;
                unique case (mode_reg)
                    MODE_COMMENT:
                    begin
                        if (source_byte == CH_NL)
                        begin
                            line_next = bump_line(line_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_CHAR:
                    begin
                        if (source_byte == CH_BSLASH)
                        begin
                            mode_next = MODE_CHAR_ESC;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                            burst.items[0] = make_tok(source_byte, 1'b1, KIND_CHAR, line_reg,
                                                      1'b1, ERR_NONE);
                            n = 2'd1;
                        end
                    end
                    MODE_CHAR_ESC:
                    begin
                        if (!esc[8])
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_ESCAPE;
                        end
                        else
                        begin
                            mode_next = MODE_IDLE;
                            burst.items[0] = make_tok(esc[7:0], 1'b1, KIND_CHAR, line_reg,
                                                      1'b1, ERR_NONE);
                            n = 2'd1;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (source_byte == CH_DQUOTE)
                        begin
                            mode_next = MODE_IDLE;
                            burst.items[0] = make_tok(8'd0, 1'b0, KIND_STRING, start_reg,
                                                      1'b1, ERR_NONE);
                            n = 2'd1;
                        end
                        else if (source_byte == CH_BSLASH)
                        begin
                            mode_next = MODE_STRING_ESC;
                        end
                        else
                        begin
                            if (source_byte == CH_NL)
                            begin
                                line_next = bump_line(line_reg);
                            end
                            burst.items[0] = make_tok(source_byte, 1'b1, KIND_STRING,
                                                      start_reg, 1'b0, ERR_NONE);
                            n = 2'd1;
                        end
                    end
                    MODE_STRING_ESC:
                    begin
                        if (!esc[8])
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_ESCAPE;
                        end
                        else
                        begin
                            mode_next = MODE_STRING;
                            burst.items[0] = make_tok(esc[7:0], 1'b1, KIND_STRING, start_reg,
                                                      1'b0, ERR_NONE);
                            n = 2'd1;
                        end
                    end
                    MODE_MINUS:
                    begin
                        if (is_digit(source_byte))
                        begin
                            mode_next = MODE_NUMBER;
                            dot_next  = 1'b0;
                            sep_next  = 1'b0;
                            burst.items[0] = make_tok(CH_MINUS, 1'b1, KIND_INTEGER, line_reg,
                                                      1'b0, ERR_NONE);
                            burst.items[1] = make_tok(source_byte, 1'b1, KIND_INTEGER,
                                                      line_reg, 1'b0, ERR_NONE);
                            n = 2'd2;
                        end
                        else
                        begin
                            mode_next = MODE_IDENT;
                            burst.items[0] = make_tok(CH_MINUS, 1'b1, KIND_IDENT, line_reg,
                                                      1'b0, ERR_NONE);
                            if (ident_end)
                            begin
                                burst.items[1] = make_tok(8'd0, 1'b0, KIND_IDENT, line_reg,
                                                          1'b1, ERR_NONE);
                                mode_next = MODE_IDLE;
                                do_idle   = 1'b1;
                            end
                            else
                            begin
                                burst.items[1] = make_tok(source_byte, 1'b1, KIND_IDENT,
                                                          line_reg, 1'b0, ERR_NONE);
                            end
                            n = 2'd2;
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(source_byte))
                        begin
                            sep_next = 1'b0;
                            burst.items[0] = make_tok(source_byte, 1'b1, num_kind, line_reg,
                                                      1'b0, ERR_NONE);
                            n = 2'd1;
                        end
                        else if ((source_byte == CH_DOT && !dot_reg) ||
                                 source_byte == CH_UNDERSCORE)
                        begin
                            if (sep_reg)
                            begin
                                failed    = 1'b1;
                                fail_code = ERR_DOUBLE;
                            end
                            else
                            begin
                                sep_next = 1'b1;
                                if (source_byte != CH_UNDERSCORE)
                                begin
                                    dot_next = 1'b1;
                                    burst.items[0] = make_tok(source_byte, 1'b1, KIND_NUMBER,
                                                              line_reg, 1'b0, ERR_NONE);
                                    n = 2'd1;
                                end
                            end
                        end
                        else if (sep_reg)
                        begin
                            failed    = 1'b1;
                            fail_code = ERR_TRAILING;
                        end
                        else
                        begin
                            burst.items[0] = make_tok(8'd0, 1'b0, num_kind, line_reg, 1'b1,
                                                      ERR_NONE);
                            n = 2'd1;
                            mode_next = MODE_IDLE;
                            do_idle   = 1'b1;
                        end
                    end
                    MODE_IDENT:
                    begin
                        if (ident_end)
                        begin
                            burst.items[0] = make_tok(8'd0, 1'b0, KIND_IDENT, line_reg, 1'b1,
                                                      ERR_NONE);
                            mode_next = MODE_IDLE;
                            do_idle   = 1'b1;
                        end
                        else
                        begin
                            burst.items[0] = make_tok(source_byte, 1'b1, KIND_IDENT,
                                                      line_reg, 1'b0, ERR_NONE);
                        end
                        n = 2'd1;
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                endcase
            end

            // Byte handling from the idle mode, also used right after a token closes.
            if (do_idle)
            begin
                if (is_space(source_byte))
                begin
                    if (source_byte == CH_NL)
                    begin
                        line_next = bump_line(line_next);
                    end
                end
                else
                begin
                    unique case (source_byte)
                        CH_SEMI: mode_next = MODE_COMMENT;
                        CH_LPAREN:
                        begin
                            burst.items[n] = make_tok(source_byte, 1'b1, KIND_LPAREN,
                                                      line_next, 1'b1, ERR_NONE);
                            n = n + 2'd1;
                        end
                        CH_RPAREN:
                        begin
                            burst.items[n] = make_tok(source_byte, 1'b1, KIND_RPAREN,
                                                      line_next, 1'b1, ERR_NONE);
                            n = n + 2'd1;
                        end
                        CH_LBRACKET:
                        begin
                            burst.items[n] = make_tok(source_byte, 1'b1, KIND_LBRACKET,
                                                      line_next, 1'b1, ERR_NONE);
                            n = n + 2'd1;
                        end
                        CH_RBRACKET:
                        begin
                            burst.items[n] = make_tok(source_byte, 1'b1, KIND_RBRACKET,
                                                      line_next, 1'b1, ERR_NONE);
                            n = n + 2'd1;
                        end
                        CH_QUOTE: mode_next = MODE_CHAR;
                        CH_DQUOTE:
                        begin
                            mode_next  = MODE_STRING;
                            start_next = line_next;
                        end
                        CH_MINUS: mode_next = MODE_MINUS;
                        default:
                        begin
                            if (is_digit(source_byte))
                            begin
                                mode_next = MODE_NUMBER;
                                dot_next  = 1'b0;
                                sep_next  = 1'b0;
                                burst.items[n] = make_tok(source_byte, 1'b1, KIND_INTEGER,
                                                          line_next, 1'b0, ERR_NONE);
                            end
                            else
                            begin
                                mode_next = MODE_IDENT;
                                burst.items[n] = make_tok(source_byte, 1'b1, KIND_IDENT,
                                                          line_next, 1'b0, ERR_NONE);
                            end
                            n = n + 2'd1;
                        end
                    endcase
                end
            end

            // A rule violation replaces everything else with one sticky error item.
            if (failed)
            begin
                mode_next      = MODE_ERROR;
                errc_next      = fail_code;
                errl_next      = fail_line;
                burst.items    = '0;
                burst.items[0] = make_tok(8'd0, 1'b0, KIND_EOF, fail_line, 1'b1, fail_code);
                n              = 2'd1;
            end
        end
        burst.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            line_reg     <= load_line(16'd1);
            start_reg    <= '0;
            dot_reg      <= 1'b0;
            sep_reg      <= 1'b0;
            errc_reg     <= ERR_NONE;
            errl_reg     <= '0;
            at_start_reg <= 1'b1;
        end
        else
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            start_reg    <= start_next;
            dot_reg      <= dot_next;
            sep_reg      <= sep_next;
            errc_reg     <= errc_next;
            errl_reg     <= errl_next;
            at_start_reg <= at_start_next;
        end
    end

    // Once an error is found, the scanner never leaves the error mode.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ERROR |=> mode_reg == MODE_ERROR)
        else $error("scanner left the error mode");

    // An end marker always yields at least the end-of-file or error item.
    a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_input |-> burst.count != 2'd0)
        else $error("end marker produced no result");

    // In the error mode each byte gives exactly one item carrying a nonzero code.
    a_error_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode_reg == MODE_ERROR |->
            burst.count == 2'd1 && burst.items[0].err != ERR_NONE)
        else $error("error mode produced a wrong item");

    // The line counter only moves on a byte transfer or a configuration write.
    a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept && !cfg_we |=> $stable(line_reg))
        else $error("line counter moved without a transfer");

endmodule

// ===== sv/lst_outq.sv =====
`timescale 1ns / 1ps
// Four-entry shifting result queue of the Lisp source tokenizer: takes a burst of up
// to three items and delivers one per cycle while out_ready is high. Depends on lst_pkg.
module lst_outq (
    input  logic            clk,
    input  logic            rst_n,
    input  lst_pkg::burst_t burst,
    output logic            space,
    output logic            out_valid,
    input  logic            out_ready,
    output lst_pkg::tok_t   out_tok
);
    import lst_pkg::*;

    localparam int DEPTH = 4;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(DEPTH);

    tok_t [DEPTH-1:0] q_reg;
    tok_t [DEPTH-1:0] q_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             pop;
    logic [CW-1:0]    base;
    logic [CW-1:0]    wi;

    assign out_valid = (cnt_reg != '0);
    assign out_tok   = q_reg[0];
    assign pop       = out_valid && out_ready;
    // Room for a full burst of three behind whatever is still waiting.
    assign space     = (cnt_reg <= CW'(DEPTH - 3));

    always_comb
    begin
        q_next = q_reg;
        base   = cnt_reg - CW'(pop);
        wi     = '0;
        if (pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            if (2'(k) < burst.count)
            begin
                wi = base + CW'(k);
                q_next[wi[IW-1:0]] = burst.items[k];
            end
        end
        cnt_next = base + CW'(burst.count);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        burst.count != 2'd0 |-> cnt_reg <= CW'(DEPTH - 3))
        else $error("burst written into a queue without room");

endmodule

// ===== sv/lisp_source_tokenizer.sv =====
`timescale 1ns / 1ps
// Top level of the Lisp source tokenizer: source channel, token channel and
// configuration port. Depends on lst_pkg, lst_scan and lst_outq.
//
// Usage: source bytes come in on the source channel (source_valid and
// source_ready), one per transfer; a transfer with end_of_input high ends the
// text, flushes any open token and yields the end-of-file item (or an error item). Token items
// leave on the token channel (token_valid and token_ready), one per transfer.
// Each source transfer yields zero to three token items, computed in the same
// cycle and written into a four-entry result queue.
//
// The items caused by a byte are registered into the queue at its transfer and
// are offered once the items ahead of them have left. One byte per cycle is taken
// while token_ready is high and each byte yields at most one item; a byte that
// yields two or three items takes a token transfer for each, so the token port
// sets the sustained rate. source_ready is high whenever the queue holds at most
// one item, so it does not depend on token_ready in the same cycle. When the
// receiver stalls, the queue fills and source_ready drops until items drain.
//
// Reset clears the scanner to idle, the queue to empty and first_line to 1.
// first_line is written through the APB port at address 0; the user is to write it
// only while the block is idle, which the block itself does not enforce. It loads the line
// counter when no byte has been taken since reset or the last end marker. An error is sticky until reset.
module lisp_source_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    // Source channel.
    input  logic        source_valid,
    output logic        source_ready,
    input  logic [7:0]  source_byte,
    input  logic        end_of_input,
    // Token channel.
    output logic        token_valid,
    input  logic        token_ready,
    output logic [7:0]  token_byte,
    output logic        byte_valid,
    output logic [3:0]  token_kind,
    output logic [15:0] token_line,
    output logic        token_last,
    output logic [2:0]  error_code,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lst_pkg::*;

    localparam logic REG_FIRST_LINE = 1'b0;

    logic        source_accept;
    logic        cfg_we;
    logic [15:0] first_line_reg;
    burst_t      burst;
    tok_t        head;

    assign pready        = 1'b1;
    assign source_accept = source_valid && source_ready;

    // Only word address 0 holds a register; other addresses are ignored.
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_LINE);
    assign prdata = (paddr[2] == REG_FIRST_LINE) ? {16'd0, first_line_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_line_reg <= 16'd1;
        end
        else if (cfg_we)
        begin
            first_line_reg <= pwdata[15:0];
        end
    end

    lst_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (source_accept),
        .source_byte    (source_byte),
        .end_of_input   (end_of_input),
        .cfg_we         (cfg_we),
        .cfg_first_line (pwdata[15:0]),
        .first_line     (first_line_reg),
        .burst          (burst)
    );

    lst_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .burst     (burst),
        .space     (source_ready),
        .out_valid (token_valid),
        .out_ready (token_ready),
        .out_tok   (head)
    );

    assign token_byte = head.text;
    assign byte_valid = head.text_valid;
    assign token_kind = head.kind;
    assign token_line = head.line;
    assign token_last = head.last;
    assign error_code = head.err;

endmodule
